>>> sv/bbm_pkg.sv
// Shared types and constants for the bip-buffer pointer manager.
// Used by bbm_step and bipartite_buffer_manager; depends on nothing.
`default_nettype none

package bbm_pkg;

  localparam int unsigned MAX_BYTES = 4096;
  localparam int unsigned PTR_W     = 13;
  localparam int unsigned OFS_W     = 12;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t MAX_PTR = ptr_t'(MAX_BYTES);

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOSPACE = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_TOOLONG = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] command;
    ptr_t       length;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFS_W-1:0] offset;
    ptr_t             used_bytes;
    ptr_t             free_bytes;
    logic             is_empty;
  } out_t;

  typedef struct packed {
    ptr_t a_start;
    ptr_t a_end;
    ptr_t b_end;
    logic b_act;
  } regions_t;

endpackage

`default_nettype wire

>>> sv/bbm_step.sv
// One command against the region pointers: next pointers and the result word.
// Purely combinational; depends on bbm_pkg.
`default_nettype none

module bbm_step import bbm_pkg::*; (
  input  wire regions_t cur,
  input  wire ptr_t     cap,
  input  wire in_t      cmd_word,
  output regions_t      nxt,
  output out_t          res
);

  ptr_t    a_len;
  ptr_t    room;
  ptr_t    new_start;
  ptr_t    ofs;
  ptr_t    tail_room;
  ptr_t    head_gap;
  status_e sts;
  logic    chk_open;

  always_comb begin
    a_len     = cur.a_end - cur.a_start;
    room      = cur.b_act ? (cur.a_start - cur.b_end) : (cap - cur.a_end);
    new_start = cur.a_start + cmd_word.length;
    nxt       = cur;
    sts       = STS_OK;
    ofs       = '0;
    chk_open  = 1'b0;

    case (cmd_word.command)
      CMD_PUT: begin
        if (cmd_word.length > room) begin
          sts = STS_NOSPACE;
        end else begin
          chk_open = 1'b1;
          if (cur.b_act) begin
            ofs       = cur.b_end;
            nxt.b_end = cur.b_end + cmd_word.length;
          end else begin
            ofs       = cur.a_end;
            nxt.a_end = cur.a_end + cmd_word.length;
          end
        end
      end
      CMD_GET: begin
        if (a_len == '0) begin
          sts = STS_EMPTY;
        end else if (cmd_word.length > a_len) begin
          sts = STS_TOOLONG;
        end else begin
          chk_open    = 1'b1;
          ofs         = cur.a_start;
          nxt.a_start = new_start;
          // A drained: B (if any) becomes the new A
          if (new_start == cur.a_end) begin
            nxt.a_start = '0;
            nxt.a_end   = cur.b_act ? cur.b_end : '0;
            nxt.b_end   = '0;
            nxt.b_act   = 1'b0;
          end
        end
      end
      CMD_PEEK: begin
        if (cmd_word.length > a_len) begin
          sts = STS_TOOLONG;
        end else if (a_len == '0) begin
          sts = STS_EMPTY;
        end else begin
          ofs = cur.a_start;
        end
      end
      default: begin
        sts = STS_OK;
      end
    endcase

    // switch writes to B once the gap before A beats the tail space
    tail_room = cap - nxt.a_end;
    head_gap  = nxt.a_start - nxt.b_end;
    if (chk_open && (tail_room < head_gap)) begin
      nxt.b_act = 1'b1;
    end

    res.status     = sts;
    res.offset     = ofs[OFS_W-1:0];
    res.used_bytes = (nxt.a_end - nxt.a_start) + nxt.b_end;
    res.free_bytes = nxt.b_act ? (nxt.a_start - nxt.b_end) : (cap - nxt.a_end);
    res.is_empty   = (nxt.a_start == nxt.a_end);
  end

endmodule

`default_nettype wire

>>> sv/bipartite_buffer_manager.sv
// Top level of the bip-buffer pointer manager: input, state and result registers.
// Depends on bbm_pkg and bbm_step.
`default_nettype none

// Takes one command (put, get or peek) per clock; busy is never raised.
// An accepted command is held in the input register; the combinational
// pointer update in bbm_step feeds both the region pointers and the
// result register, from which the result word is on out_data with
// out_strobe high.
// The result is shown for exactly one cycle and cannot be held off.
// Writing cfg_wdata sets the capacity (0 reads as 1, values above 4096 as
// 4096) and empties the buffer; write it only when no command is in flight.
module bipartite_buffer_manager import bbm_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data,
  input  wire       cfg_we,
  input  wire ptr_t cfg_wdata
);

  logic     in_vld_r;
  in_t      in_word_r;
  regions_t reg_r;
  regions_t reg_nxt;
  ptr_t     cap_r;
  ptr_t     cap_nxt;
  logic     out_strobe_r;
  out_t     out_word_r;
  out_t     res;

  assign busy = 1'b0;

  always_comb begin
    cap_nxt = cfg_wdata;
    if (cfg_wdata == '0) begin
      cap_nxt = ptr_t'(1);
    end else if (cfg_wdata > MAX_PTR) begin
      cap_nxt = MAX_PTR;
    end
  end

  bbm_step u_step (
    .cur      (reg_r),
    .cap      (cap_r),
    .cmd_word (in_word_r),
    .nxt      (reg_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      reg_r        <= '0;
      cap_r        <= MAX_PTR;
    end else begin
      in_vld_r     <= start && !busy;
      out_strobe_r <= in_vld_r;
      if (cfg_we) begin
        cap_r <= cap_nxt;
        reg_r <= '0;
      end else if (in_vld_r) begin
        reg_r <= reg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word_r <= in_data;
    end
    if (in_vld_r) begin
      out_word_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_word_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("accepted command produced no result word");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (reg_r.a_start <= reg_r.a_end) && (reg_r.a_end <= cap_r))
    else $error("region A pointers out of order");

  a_b_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !reg_r.b_act |-> (reg_r.b_end == '0))
    else $error("region B end nonzero while B inactive");

  a_b_below_a: assert property (@(posedge clk) disable iff (!rst_n)
    reg_r.b_act |-> (reg_r.b_end <= reg_r.a_start))
    else $error("region B overlaps region A");

  a_fail_ofs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.status != STS_OK)) |-> (out_data.offset == '0))
    else $error("failed command reported a nonzero offset");
`endif

endmodule

`default_nettype wire
